[design/bstpc_pkg.sv]
// ----------------------------------------------------------------------------
// bstpc_pkg
// Types, codes and helpers shared by the bit scan / test / popcount pipeline.
// ----------------------------------------------------------------------------
package bstpc_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrWidth = 64;
  localparam int unsigned IdxWidth  = $clog2(DataWidth);
  localparam int unsigned CntWidth  = $clog2(DataWidth) + 1;
  localparam int unsigned NumBytes  = DataWidth / 8;

  // Operation codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    KIND_BSF    = 3'd0,
    KIND_BSR    = 3'd1,
    KIND_BT     = 3'd2,
    KIND_BTS    = 3'd3,
    KIND_BTR    = 3'd4,
    KIND_BTC    = 3'd5,
    KIND_POPCNT = 3'd6
  } kind_e;

  // Unassigned code, executed as a plain bit test.
  localparam logic [2:0] KIND_CODE_ALT = 3'd7;

  // Which flags an item changes.
  typedef enum logic [1:0] {
    UPD_CF  = 2'd0,
    UPD_ZF  = 2'd1,
    UPD_ALL = 2'd2
  } upd_e;

  // Address size codes; the spare code also means 64-bit.
  localparam logic [1:0] ASZ_16   = 2'd0;
  localparam logic [1:0] ASZ_32   = 2'd1;
  localparam logic [1:0] ASZ_64   = 2'd2;
  localparam logic [1:0] ASZ_RSVD = 2'd3;

  typedef struct packed {
    logic [2:0]           kind;
    logic [DataWidth-1:0] source_value;
    logic [DataWidth-1:0] bit_offset;
    logic                 memory_form;
    logic                 offset_from_register;
    logic [AddrWidth-1:0] base_address;
    logic [1:0]           address_size;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] result_value;
    logic                 write_dest;
    logic [AddrWidth-1:0] operand_address;
    logic                 carry_flag;
    logic                 zero_flag;
    logic                 sign_flag;
    logic                 parity_flag;
    logic                 overflow_flag;
    logic                 adjust_flag;
    logic [1:0]           flags_update;
  } out_item_t;

  // Stage 1 -> stage 2: decoded operation, raw address, per-byte counts.
  typedef struct packed {
    kind_e                          kind;
    logic [DataWidth-1:0]           src;
    logic [IdxWidth-1:0]            idx;
    logic [AddrWidth-1:0]           addr_raw;
    logic [1:0]                     asize;
    logic [NumBytes-1:0][3:0]       byte_cnt;
  } s1_t;

  // Stage 2 -> stage 3: scan index, count, modified word, final address.
  typedef struct packed {
    kind_e                kind;
    logic                 src_zero;
    logic [IdxWidth-1:0]  scan_idx;
    logic [CntWidth-1:0]  count;
    logic [DataWidth-1:0] bit_word;
    logic                 tested_bit;
    logic [AddrWidth-1:0] addr;
  } s2_t;

  // Number of set bits in one byte.
  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'b000, b[k]};
    end
    return n;
  endfunction

endpackage

[design/bstpc_decode.sv]
// ----------------------------------------------------------------------------
// bstpc_decode
// Stage 1: decode the operation, form the displaced address, count each byte.
// ----------------------------------------------------------------------------
module bstpc_decode import bstpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     ready_i,
  output s1_t      data_o
);

  logic valid_q;
  s1_t  data_d, data_q;
  logic is_bit_op;
  logic [AddrWidth-1:0] disp;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    unique case (item_i.kind)
      KIND_BSF:      data_d.kind = KIND_BSF;
      KIND_BSR:      data_d.kind = KIND_BSR;
      KIND_BT:       data_d.kind = KIND_BT;
      KIND_BTS:      data_d.kind = KIND_BTS;
      KIND_BTR:      data_d.kind = KIND_BTR;
      KIND_BTC:      data_d.kind = KIND_BTC;
      KIND_POPCNT:   data_d.kind = KIND_POPCNT;
      default:       data_d.kind = KIND_BT;
    endcase

    is_bit_op = (data_d.kind == KIND_BT) || (data_d.kind == KIND_BTS) ||
                (data_d.kind == KIND_BTR) || (data_d.kind == KIND_BTC);

    // Signed offset / 32, scaled to bytes of a dword.
    disp = {{(AddrWidth - DataWidth + 3){item_i.bit_offset[DataWidth-1]}},
            item_i.bit_offset[DataWidth-1:IdxWidth], 2'b00};

    if (!item_i.memory_form) begin
      data_d.addr_raw = '0;
    end else if (is_bit_op && item_i.offset_from_register) begin
      data_d.addr_raw = item_i.base_address + disp;
    end else begin
      data_d.addr_raw = item_i.base_address;
    end

    data_d.src   = item_i.source_value;
    data_d.idx   = item_i.bit_offset[IdxWidth-1:0];
    data_d.asize = item_i.address_size;
    for (int b = 0; b < NumBytes; b++) begin
      data_d.byte_cnt[b] = popcnt8(item_i.source_value[8*b +: 8]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Load payload only on accept.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/bstpc_execute.sv]
// ----------------------------------------------------------------------------
// bstpc_execute
// Stage 2: scan encoders, popcount sum, bit modify, address truncation.
// ----------------------------------------------------------------------------
module bstpc_execute import bstpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s2_t  data_o
);

  logic valid_q;
  s2_t  data_d, data_q;
  logic [IdxWidth-1:0]  fwd_idx, rev_idx;
  logic [DataWidth-1:0] mask;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // Lowest set bit wins for forward, highest for reverse.
    fwd_idx = '0;
    for (int k = DataWidth - 1; k >= 0; k--) begin
      if (data_i.src[k]) fwd_idx = IdxWidth'(k);
    end
    rev_idx = '0;
    for (int k = 0; k < DataWidth; k++) begin
      if (data_i.src[k]) rev_idx = IdxWidth'(k);
    end

    mask = {{(DataWidth-1){1'b0}}, 1'b1} << data_i.idx;

    data_d.kind       = data_i.kind;
    data_d.src_zero   = (data_i.src == '0);
    data_d.scan_idx   = (data_i.kind == KIND_BSR) ? rev_idx : fwd_idx;
    data_d.tested_bit = data_i.src[data_i.idx];

    data_d.count = '0;
    for (int b = 0; b < NumBytes; b++) begin
      data_d.count = data_d.count + CntWidth'(data_i.byte_cnt[b]);
    end

    unique case (data_i.kind)
      KIND_BTS: data_d.bit_word = data_i.src | mask;
      KIND_BTR: data_d.bit_word = data_i.src & ~mask;
      KIND_BTC: data_d.bit_word = data_i.src ^ mask;
      default:  data_d.bit_word = '0;
    endcase

    unique case (data_i.asize)
      ASZ_16:  data_d.addr = {{(AddrWidth-16){1'b0}}, data_i.addr_raw[15:0]};
      ASZ_32:  data_d.addr = {{(AddrWidth-32){1'b0}}, data_i.addr_raw[31:0]};
      default: data_d.addr = data_i.addr_raw;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/bstpc_writeback.sv]
// ----------------------------------------------------------------------------
// bstpc_writeback
// Stage 3: pick the result word and build the flag update; output register.
// ----------------------------------------------------------------------------
module bstpc_writeback import bstpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  s2_t       data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t item_o
);

  logic      valid_q;
  out_item_t item_d, item_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    item_d                 = '0;
    item_d.operand_address = data_i.addr;

    unique case (data_i.kind)
      KIND_BSF, KIND_BSR: begin
        if (data_i.src_zero) begin
          item_d.zero_flag    = 1'b1;
          item_d.flags_update = UPD_ZF;
        end else begin
          item_d.result_value = {{(DataWidth-IdxWidth){1'b0}}, data_i.scan_idx};
          item_d.write_dest   = 1'b1;
          item_d.parity_flag  = ~^data_i.scan_idx;
          item_d.flags_update = UPD_ALL;
        end
      end
      KIND_POPCNT: begin
        item_d.result_value = {{(DataWidth-CntWidth){1'b0}}, data_i.count};
        item_d.write_dest   = 1'b1;
        item_d.zero_flag    = (data_i.count == '0);
        item_d.flags_update = UPD_ALL;
      end
      default: begin
        item_d.result_value = data_i.bit_word;
        item_d.write_dest   = (data_i.kind != KIND_BT);
        item_d.carry_flag   = data_i.tested_bit;
        item_d.flags_update = UPD_CF;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[design/bit_scan_test_popcount_unit.sv]
// ----------------------------------------------------------------------------
// bit_scan_test_popcount_unit
// Three-stage pipelined executor for 32-bit BSF, BSR, BT, BTS, BTR, BTC and
// POPCNT, returning the result word, destination write and flag update.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   in      | into unit | in_valid_i / in_ready_o   | in_item_i  (in_item_t)
//   out     | from unit | out_valid_o / out_ready_i | out_item_o (out_item_t)
//
// One item enters per cycle while the output is not stalled; each result
// is registered in the decode, execute and writeback stages in turn and is
// then presented on the output, held there until the sink takes it. Reset
// clears only the stage valid bits; payload registers
// are loaded on accept and hold otherwise. A stall on the output backs up
// through the per-stage ready chain: each stage takes a new item whenever it
// is empty or its successor is moving, so bubbles collapse and no item is
// dropped or repeated.
//
// Stage 1 (decode): normalize the operation code, add the signed dword
//   displacement to the base address for register-offset memory bit ops,
//   count the set bits of each source byte.
// Stage 2 (execute): forward and reverse priority encoders, sum of the byte
//   counts, set / reset / complement of the addressed bit, tested bit, and
//   truncation of the address to the address size.
// Stage 3 (writeback): select the result for the operation and build the
//   flag values and update class; this register drives the output port.
// ----------------------------------------------------------------------------
module bit_scan_test_popcount_unit import bstpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Stage handshakes and payloads.
  logic s1_valid, s1_ready;
  s1_t  s1_data;
  logic s2_valid, s2_ready;
  s2_t  s2_data;

  // Decode: operation code, displaced address, byte counts.
  bstpc_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Execute: scans, popcount sum, bit modify, address truncation.
  bstpc_execute u_execute (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Writeback: result select and flags; holds the output item.
  bstpc_writeback u_writeback (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

`ifndef SYNTH
  // A sink that is ready never throttles the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

  // An accepted item reaches the output if the sink keeps up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("item lost in pipeline");

  // No destination write means a zero result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.write_dest |-> out_item_o.result_value == '0)
    else $error("unwritten result is nonzero");

  // A ZF-only update is a scan of zero: ZF set, nothing written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.flags_update == UPD_ZF
      |-> out_item_o.zero_flag && !out_item_o.write_dest)
    else $error("bad zero-source scan result");

  // Bit ops touch only CF.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.flags_update == UPD_CF
      |-> !out_item_o.zero_flag && !out_item_o.parity_flag && !out_item_o.sign_flag)
    else $error("bit op produced stray flags");
`endif

endmodule
